// ===== rtl/core/drq_pkg.sv =====
// drq_pkg: shared types, constants and codes of the deadline ordered run queue
// no dependencies
`timescale 1ns / 1ps

package drq_pkg;

  // queue geometry
  localparam int QDEPTH      = 64;
  localparam int CNT_W       = $clog2(QDEPTH + 1);

  // fixed field widths
  localparam int ID_W        = 6;
  localparam int DL_W        = 32;
  localparam int NICE_W      = 7;
  localparam int QT_W        = 16;
  localparam int STEP_W      = 8;
  localparam int PROD_W      = QT_W + STEP_W;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_IDX_W   = 2;

  // small queues between and after the two halves (power of two depths)
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH  = 2;
  localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

  // register reset values
  localparam logic [QT_W-1:0]          QUANTUM_RST   = 16'd6;
  localparam logic signed [NICE_W-1:0] LOW_NICE_RST  = -7'sd20;
  localparam logic signed [NICE_W-1:0] HIGH_NICE_RST = 7'sd19;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REQUEUE = 2'd2,
    OP_PEEK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_BAD_NICE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM   = 2'd0,
    CFG_LOW_NICE  = 2'd1,
    CFG_HIGH_NICE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [QT_W-1:0]          quantum;
    logic signed [NICE_W-1:0] low_nice;
    logic signed [NICE_W-1:0] high_nice;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic            bad_nice;
    logic [DL_W-1:0] dl;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic             head_valid;
    logic [ID_W-1:0]  head_id;
    logic [DL_W-1:0]  head_dl;
    logic [DL_W-1:0]  assigned_dl;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// ===== rtl/core/drq_front.sv =====
// drq_front: accepts items, checks nice range and computes the virtual deadline
// depends on drq_pkg
`timescale 1ns / 1ps

module drq_front import drq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               op_i,
  input  logic [ID_W-1:0]          task_id_i,
  input  logic signed [NICE_W-1:0] nice_i,
  input  logic [DL_W-1:0]          now_tick_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  logic                     cmd_full_i
);

  logic                  accept;
  logic                  uses_nice;
  logic                  bad_d;
  logic [NICE_W+1:0]     steps_wide;
  logic [PROD_W-1:0]     prod_d;
  logic [DL_W:0]         sum;

  logic                  f1_valid_q, f1_valid_d;
  op_e                   f1_op_q;
  logic [ID_W-1:0]       f1_id_q;
  logic                  f1_bad_q;
  logic [DL_W-1:0]       f1_now_q;
  logic [PROD_W-1:0]     f1_prod_q;

  assign full   = f1_valid_q && cmd_full_i;
  assign accept = push && !full;

  // range check only matters for insert and requeue
  assign uses_nice = (op_i == OP_INSERT) || (op_i == OP_REQUEUE);
  assign bad_d     = uses_nice && (($signed(nice_i) < $signed(cfg_i.low_nice)) ||
                                   ($signed(nice_i) > $signed(cfg_i.high_nice)));

  // nice - lowest + 1 lies in 1..128 whenever the nice is in range
  assign steps_wide = {{2{nice_i[NICE_W-1]}}, nice_i}
                    - {{2{cfg_i.low_nice[NICE_W-1]}}, cfg_i.low_nice}
                    + (NICE_W+2)'(1);
  assign prod_d     = PROD_W'(steps_wide[STEP_W-1:0]) * PROD_W'(cfg_i.quantum);

  always_comb begin
    f1_valid_d = f1_valid_q;
    if (accept) begin
      f1_valid_d = 1'b1;
    end else if (f1_valid_q && !cmd_full_i) begin
      f1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_op_q   <= op_e'(op_i);
      f1_id_q   <= task_id_i;
      f1_bad_q  <= bad_d;
      f1_now_q  <= now_tick_i;
      f1_prod_q <= prod_d;
    end
  end

  // add and saturate after the product register
  assign sum = {1'b0, f1_now_q} + (DL_W+1)'(f1_prod_q);

  assign cmd_valid_o     = f1_valid_q;
  assign cmd_o.op        = f1_op_q;
  assign cmd_o.id        = f1_id_q;
  assign cmd_o.bad_nice  = f1_bad_q;
  assign cmd_o.dl        = sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];

endmodule

// ===== rtl/core/drq_cmd_queue.sv =====
// drq_cmd_queue: short command queue between the front and back halves
// depends on drq_pkg
`timescale 1ns / 1ps

module drq_cmd_queue import drq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_en_i,
  output logic valid_o,
  output cmd_t rd_cmd_o
);

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  do_wr, do_rd;

  assign full_o   = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && valid_o;
  assign rd_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + CMDQ_PTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + CMDQ_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CMDQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CMDQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== rtl/core/drq_back.sv =====
// drq_back: sorted cell array that carries out commands, plus the result queue
// depends on drq_pkg
`timescale 1ns / 1ps

module drq_back import drq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_pop_i,
  output logic res_empty_o,
  output res_t res_o
);

  logic [ID_W-1:0]  task_q [QDEPTH];
  logic [DL_W-1:0]  dl_q   [QDEPTH];
  logic [CNT_W-1:0] count_q;

  logic [QDEPTH-1:0] match, above, take;
  logic              found;
  logic [ID_W-1:0]   rem_task [QDEPTH];
  logic [DL_W-1:0]   rem_dl   [QDEPTH];
  logic [ID_W-1:0]   nxt_task [QDEPTH];
  logic [DL_W-1:0]   nxt_dl   [QDEPTH];
  logic [CNT_W-1:0]  rem_count, nxt_count;
  logic              do_ins, do_rem, exec;
  status_e           status;
  res_t              res;

  res_t                  resq_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [RESQ_CNT_W-1:0] rcnt_q;
  logic                  res_full, res_rd;

  // every cell compares and shifts in parallel
  always_comb begin
    int nb;
    int pv;
    for (int i = 0; i < QDEPTH; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (task_q[i] == cmd_i.id);
    end
    found = |match;
    // cells at or above the match take their upper neighbour
    for (int i = 0; i < QDEPTH; i++) begin
      nb = (i < QDEPTH - 1) ? i + 1 : i;
      above[i] = |(match & ({QDEPTH{1'b1}} >> (QDEPTH - 1 - i)));
      rem_task[i] = above[i] ? task_q[nb] : task_q[i];
      rem_dl[i]   = above[i] ? dl_q[nb]   : dl_q[i];
    end
    rem_count = found ? count_q - CNT_W'(1) : count_q;
    // new entry goes ahead of equal deadlines
    for (int i = 0; i < QDEPTH; i++) begin
      take[i] = (CNT_W'(i) >= rem_count) || (rem_dl[i] >= cmd_i.dl);
    end
    for (int i = 0; i < QDEPTH; i++) begin
      pv = (i > 0) ? i - 1 : 0;
      if (take[i] && (i > 0) && take[pv]) begin
        nxt_task[i] = rem_task[pv];
        nxt_dl[i]   = rem_dl[pv];
      end else if (take[i]) begin
        nxt_task[i] = cmd_i.id;
        nxt_dl[i]   = cmd_i.dl;
      end else begin
        nxt_task[i] = rem_task[i];
        nxt_dl[i]   = rem_dl[i];
      end
    end
  end

  always_comb begin
    status = ST_OK;
    do_ins = 1'b0;
    do_rem = 1'b0;
    case (cmd_i.op)
      OP_INSERT, OP_REQUEUE: begin
        if (cmd_i.bad_nice) begin
          status = ST_BAD_NICE;
        end else if ((cmd_i.op == OP_REQUEUE) && !found) begin
          status = ST_ABSENT;
        end else if (!found && (count_q == CNT_W'(QDEPTH))) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          do_rem = 1'b1;
        end else begin
          status = ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    nxt_count = count_q;
    if (do_ins) begin
      nxt_count = rem_count + CNT_W'(1);
    end else if (do_rem) begin
      nxt_count = rem_count;
    end
  end

  // result reflects the queue after this command
  always_comb begin
    res.status      = status;
    res.head_valid  = (nxt_count != '0);
    res.assigned_dl = do_ins ? cmd_i.dl : '0;
    res.count       = nxt_count;
    if (nxt_count == '0) begin
      res.head_id = '0;
      res.head_dl = '0;
    end else if (do_ins) begin
      res.head_id = nxt_task[0];
      res.head_dl = nxt_dl[0];
    end else if (do_rem) begin
      res.head_id = rem_task[0];
      res.head_dl = rem_dl[0];
    end else begin
      res.head_id = task_q[0];
      res.head_dl = dl_q[0];
    end
  end

  assign exec      = cmd_valid_i && !res_full;
  assign cmd_pop_o = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec) begin
      count_q <= nxt_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && do_ins) begin
      task_q <= nxt_task;
      dl_q   <= nxt_dl;
    end else if (exec && do_rem) begin
      task_q <= rem_task;
      dl_q   <= rem_dl;
    end
  end

  // result queue
  assign res_full    = (rcnt_q == RESQ_CNT_W'(RESQ_DEPTH));
  assign res_empty_o = (rcnt_q == '0);
  assign res_rd      = res_pop_i && !res_empty_o;
  assign res_o       = resq_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      rcnt_q <= '0;
    end else begin
      if (exec) begin
        wptr_q <= wptr_q + RESQ_PTR_W'(1);
      end
      if (res_rd) begin
        rptr_q <= rptr_q + RESQ_PTR_W'(1);
      end
      if (exec && !res_rd) begin
        rcnt_q <= rcnt_q + RESQ_CNT_W'(1);
      end else if (res_rd && !exec) begin
        rcnt_q <= rcnt_q - RESQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      resq_q[wptr_q] <= res;
    end
  end

endmodule

// ===== rtl/core/deadline_ordered_run_queue_core.sv =====
// deadline ordered run queue: items pass the front register, command queue and result
// queue; throughput one item per cycle while results are popped; front stage, 2-entry
// command queue and 2-entry result queue let either side stall on its own; the back
// executes one command per cycle when not stalled, over a 64-cell sorted shift array
// asynchronous active-low reset empties the queue and loads quantum 6, nice range -20..19
`timescale 1ns / 1ps

module deadline_ordered_run_queue_core import drq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [QT_W-1:0]          cfg_data_i,
  // item input
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               op_i,
  input  logic [ID_W-1:0]          task_id_i,
  input  logic signed [NICE_W-1:0] nice_i,
  input  logic [DL_W-1:0]          now_tick_i,
  // result output
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               status_o,
  output logic                     head_valid_o,
  output logic [ID_W-1:0]          head_id_o,
  output logic [DL_W-1:0]          head_deadline_o,
  output logic [DL_W-1:0]          assigned_deadline_o,
  output logic [COUNT_OUT_W-1:0]   queued_count_o
);

  cfg_t cfg_q;
  cmd_t front_cmd, back_cmd;
  logic front_valid;
  logic cmdq_full, cmdq_valid, cmdq_pop;
  res_t res;

  // configuration registers, always ready; unused index is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quantum   <= QUANTUM_RST;
      cfg_q.low_nice  <= LOW_NICE_RST;
      cfg_q.high_nice <= HIGH_NICE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_QUANTUM:   cfg_q.quantum   <= cfg_data_i;
        CFG_LOW_NICE:  cfg_q.low_nice  <= cfg_data_i[NICE_W-1:0];
        CFG_HIGH_NICE: cfg_q.high_nice <= cfg_data_i[NICE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: nice check, product, then saturating add into the command queue
  drq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .task_id_i   (task_id_i),
    .nice_i      (nice_i),
    .now_tick_i  (now_tick_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_full_i  (cmdq_full)
  );

  // decoupling queue between the halves
  drq_cmd_queue u_cmdq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (front_valid),
    .wr_cmd_i (front_cmd),
    .full_o   (cmdq_full),
    .rd_en_i  (cmdq_pop),
    .valid_o  (cmdq_valid),
    .rd_cmd_o (back_cmd)
  );

  // back: sorted cells and result queue
  drq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmdq_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmdq_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign status_o            = res.status;
  assign head_valid_o        = res.head_valid;
  assign head_id_o           = res.head_id;
  assign head_deadline_o     = res.head_dl;
  assign assigned_deadline_o = res.assigned_dl;
  assign queued_count_o      = COUNT_OUT_W'(res.count);

  // count never goes past the cell array
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (queued_count_o <= COUNT_OUT_W'(QDEPTH)))
    else $error("queued count beyond queue depth");

  // head flag agrees with the count
  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (head_valid_o == (queued_count_o != '0)))
    else $error("head valid disagrees with queued count");

  // only a successful insert or requeue hands out a deadline
  a_assigned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != ST_OK)) |-> (assigned_deadline_o == '0))
    else $error("deadline assigned on a failed item");

  // empty queue reports a zero head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !head_valid_o) |-> ((head_id_o == '0) && (head_deadline_o == '0)))
    else $error("head fields not cleared on empty queue");

endmodule

// ===== sim/deadline_ordered_run_queue_core_tb.sv =====
// testbench for deadline_ordered_run_queue_core: directed cases, a fill to full depth and
// random traffic under several register settings, every result checked against a local predictor
// depends on drq_pkg and the run queue core
`timescale 1ns / 1ps

module deadline_ordered_run_queue_core_tb;
  import drq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  // one result item as the block should report it
  typedef struct {
    status_e         status;
    bit              head_valid;
    bit [ID_W-1:0]   head_id;
    bit [DL_W-1:0]   head_dl;
    bit [DL_W-1:0]   assigned_dl;
    bit [6:0]        count;
  } run_result_t;

  // dut ports
  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  cfg_idx_e                 cfg_index_i;
  logic [QT_W-1:0]          cfg_data_i;
  logic                     push;
  logic                     full;
  logic [1:0]               op_i;
  logic [ID_W-1:0]          task_id_i;
  logic signed [NICE_W-1:0] nice_i;
  logic [DL_W-1:0]          now_tick_i;
  logic                     empty;
  logic                     pop;
  logic [1:0]               status_o;
  logic                     head_valid_o;
  logic [ID_W-1:0]          head_id_o;
  logic [DL_W-1:0]          head_deadline_o;
  logic [DL_W-1:0]          assigned_deadline_o;
  logic [COUNT_OUT_W-1:0]   queued_count_o;

  // predictor copy of the registers and of the sorted queue
  bit [QT_W-1:0]   quantum;
  int              low_nice;
  int              high_nice;
  bit [ID_W-1:0]   rq_task[QDEPTH];
  bit [DL_W-1:0]   rq_deadline[QDEPTH];
  int              rq_count;

  run_result_t     expected_results[$];
  run_result_t     want;
  int              error_count;
  int              results_checked;
  int              op_seen[4];
  int              status_seen[4];
  int              deepest;
  int unsigned     cycle_count = 0;
  bit [DL_W-1:0]   tick_base;
  int              send_calm_left;
  int              pop_calm_left;
  int              pop_stall_left;

  deadline_ordered_run_queue_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .push                (push),
    .full                (full),
    .op_i                (op_i),
    .task_id_i           (task_id_i),
    .nice_i              (nice_i),
    .now_tick_i          (now_tick_i),
    .empty               (empty),
    .pop                 (pop),
    .status_o            (status_o),
    .head_valid_o        (head_valid_o),
    .head_id_o           (head_id_o),
    .head_deadline_o     (head_deadline_o),
    .assigned_deadline_o (assigned_deadline_o),
    .queued_count_o      (queued_count_o)
  );

  // clock, 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  // close the gap left by the entry at pos
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < rq_count; i++) begin
      rq_task[i]     = rq_task[i + 1];
      rq_deadline[i] = rq_deadline[i + 1];
    end
    rq_count--;
  endfunction

  // apply one item to the local queue and return the result it should give
  function automatic run_result_t predict_run_queue(op_e op, bit [ID_W-1:0] id,
                                                    bit signed [NICE_W-1:0] nice,
                                                    bit [DL_W-1:0] now);
    run_result_t r;
    int          pos;
    int          nv;
    int          ins;
    bit [63:0]   sum;
    bit [DL_W-1:0] dl;
    pos = -1;
    for (int i = 0; i < rq_count; i++)
      if (pos < 0 && rq_task[i] == id) pos = i;
    nv = nice;
    r.status      = ST_OK;
    r.assigned_dl = '0;
    if (op == OP_INSERT || op == OP_REQUEUE) begin
      // nice range is checked ahead of everything else
      if (nv < low_nice || nv > high_nice) begin
        r.status = ST_BAD_NICE;
      end else if (op == OP_REQUEUE && pos < 0) begin
        r.status = ST_ABSENT;
      end else if (pos < 0 && rq_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        sum = 64'(now) + 64'(nv - low_nice + 1) * 64'(quantum);
        dl  = (sum > 64'hFFFF_FFFF) ? '1 : sum[DL_W-1:0];
        // insert of a queued task behaves as requeue
        if (pos >= 0) drop_entry(pos);
        // new entry goes ahead of any equal deadline
        ins = 0;
        while (ins < rq_count && rq_deadline[ins] < dl) ins++;
        for (int i = rq_count; i > ins; i--) begin
          rq_task[i]     = rq_task[i - 1];
          rq_deadline[i] = rq_deadline[i - 1];
        end
        rq_task[ins]     = id;
        rq_deadline[ins] = dl;
        rq_count++;
        r.assigned_dl = dl;
      end
    end else if (op == OP_REMOVE) begin
      if (pos < 0) r.status = ST_ABSENT;
      else drop_entry(pos);
    end
    r.head_valid = (rq_count > 0);
    r.head_id    = (rq_count > 0) ? rq_task[0] : '0;
    r.head_dl    = (rq_count > 0) ? rq_deadline[0] : '0;
    r.count      = 7'(rq_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // random choices
  // ---------------------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sender gap, with stretches of back to back items
  function automatic int next_send_gap();
    if (send_calm_left > 0) begin
      send_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) send_calm_left = $urandom_range(20, 60);
    return pick_gap();
  endfunction

  // half the time a task that is already queued, so remove and requeue hit
  function automatic bit [ID_W-1:0] pick_id();
    if (rq_count > 0 && $urandom_range(0, 1) == 1)
      return rq_task[$urandom_range(0, rq_count - 1)];
    return ID_W'($urandom_range(0, 63));
  endfunction

  // inside the allowed range unless bad_pct says otherwise or the range is empty
  function automatic bit signed [NICE_W-1:0] pick_nice(int bad_pct);
    int v;
    if (low_nice <= high_nice && $urandom_range(0, 99) >= bad_pct)
      v = low_nice + int'($urandom_range(0, high_nice - low_nice));
    else
      v = int'($urandom_range(0, 127)) - 64;
    return NICE_W'(v);
  endfunction

  // a rising tick, with random jumps and values close to the top of the range
  function automatic bit [DL_W-1:0] pick_now();
    int r;
    r = $urandom_range(0, 99);
    tick_base = tick_base + $urandom_range(0, 40);
    if (r < 10) return $urandom;
    if (r < 16) return 32'hFFFF_FFFF - $urandom_range(0, 512);
    return tick_base;
  endfunction

  // ---------------------------------------------------------------------------------------
  // shared drivers and checker
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_v);
    $display("mismatch at result %0d, cycle %0d: %s is %0h, expected %0h",
             results_checked, cycle_count, what, got, exp_v);
    error_count++;
  endtask

  // drive one item, wait for it to be taken, then record what it should produce
  task automatic run_item(op_e op, bit [ID_W-1:0] id, bit signed [NICE_W-1:0] nice,
                          bit [DL_W-1:0] now);
    int          gap;
    run_result_t r;
    gap = next_send_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i       = op;
    task_id_i  = id;
    nice_i     = nice;
    now_tick_i = now;
    push       = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    r = predict_run_queue(op, id, nice, now);
    expected_results.push_back(r);
    op_seen[op]++;
    status_seen[r.status]++;
    if (rq_count > deepest) deepest = rq_count;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected result has been taken
  task automatic wait_idle();
    push = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one register write, called at a falling edge with the block idle
  task automatic write_register(cfg_idx_e idx, bit [QT_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_QUANTUM:   quantum = data;
      CFG_LOW_NICE:  low_nice = int'($signed(data[NICE_W-1:0]));
      CFG_HIGH_NICE: high_nice = int'($signed(data[NICE_W-1:0]));
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // result side: random stalls with calm stretches, one assignment per falling edge
  initial begin
    pop = 1'b0;
    pop_calm_left  = 0;
    pop_stall_left = 0;
    forever begin
      @(negedge clk_i);
      pop = (pop_stall_left == 0);
      if (pop_stall_left > 0) begin
        pop_stall_left--;
      end else if (pop_calm_left > 0) begin
        pop_calm_left--;
      end else if ($urandom_range(0, 99) < 2) begin
        pop_calm_left = $urandom_range(30, 80);
      end else if ($urandom_range(0, 99) < 25) begin
        pop_stall_left = pick_gap();
      end
    end
  end

  // every taken result is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", status_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", status_o, want.status);
        if (head_valid_o != want.head_valid)
          report_mismatch("head_valid", head_valid_o, want.head_valid);
        if (head_id_o != want.head_id)
          report_mismatch("head_id", head_id_o, want.head_id);
        if (head_deadline_o != want.head_dl)
          report_mismatch("head_deadline", head_deadline_o, want.head_dl);
        if (assigned_deadline_o != want.assigned_dl)
          report_mismatch("assigned_deadline", assigned_deadline_o, want.assigned_dl);
        if (queued_count_o != want.count)
          report_mismatch("queued_count", queued_count_o, want.count);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // reset register values: quantum 6, nice -20..19
  task automatic test_directed_cases();
    run_item(OP_PEEK,    6'd0,  7'sd0,   32'd0);          // empty queue reports no head
    run_item(OP_REMOVE,  6'd5,  7'sd0,   32'd0);          // absent task
    run_item(OP_REQUEUE, 6'd5,  7'sd0,   32'd10);         // absent task on requeue
    run_item(OP_REQUEUE, 6'd5,  7'sd20,  32'd10);         // bad nice wins over absent
    run_item(OP_INSERT,  6'd7,  -7'sd21, 32'd10);         // just below the range
    run_item(OP_INSERT,  6'd7,  7'sd20,  32'd10);         // just above the range
    run_item(OP_INSERT,  6'd10, -7'sd64, 32'd10);         // field extremes
    run_item(OP_INSERT,  6'd11, 7'sd63,  32'd10);
    run_item(OP_INSERT,  6'd7,  -7'sd20, 32'd100);        // one quantum
    run_item(OP_INSERT,  6'd8,  7'sd19,  32'd100);        // forty quanta
    run_item(OP_INSERT,  6'd9,  -7'sd20, 32'd100);        // equal deadline goes ahead
    run_item(OP_INSERT,  6'd12, 7'sd0,   32'hFFFF_FFF0);  // sum saturates
    run_item(OP_INSERT,  6'd63, 7'sd19,  32'hFFFF_FFFF);  // saturated tie
    run_item(OP_INSERT,  6'd13, -7'sd20, 32'd0);          // new head
    run_item(OP_INSERT,  6'd7,  7'sd5,   32'd50);         // insert of queued task requeues
    run_item(OP_REQUEUE, 6'd8,  -7'sd1,  32'd200);
    run_item(OP_PEEK,    6'd63, -7'sd1,  32'hFFFF_FFFF);
    run_item(OP_REMOVE,  6'd13, 7'sd0,   32'd0);          // drop the head
    run_item(OP_REMOVE,  6'd12, 7'sd0,   32'd0);
    run_item(OP_REMOVE,  6'd40, 7'sd0,   32'd0);
    run_item(OP_REQUEUE, 6'd63, 7'sd19,  32'd0);          // tail moves forward
    run_item(OP_INSERT,  6'd0,  -7'sd20, 32'h5555_AAAA);
    wait_idle();
  endtask

  // every id queued in random order, then drained again; with 64 ids and 64 slots
  // an absent id never meets a full queue
  task automatic test_fill_to_capacity();
    int order[64];
    int j;
    int t;
    for (int i = 0; i < 64; i++) order[i] = i;
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 64; i++)
      run_item(OP_INSERT, ID_W'(order[i]), pick_nice(0), pick_now());
    run_item(OP_PEEK, pick_id(), pick_nice(0), pick_now());
    for (int i = 0; i < 6; i++)
      run_item((i % 2) ? OP_REQUEUE : OP_INSERT, pick_id(), pick_nice(30), pick_now());
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 64; i++)
      run_item(OP_REMOVE, ID_W'(order[i]), pick_nice(50), pick_now());
    wait_idle();
  endtask

  // load a register setting while idle, then a stretch of mixed operations
  task automatic test_random_traffic(bit [QT_W-1:0] q, int lo, int hi, int n_items);
    int  r;
    op_e op;
    wait_idle();
    write_register(CFG_QUANTUM, q);
    write_register(CFG_LOW_NICE, 16'(lo));
    write_register(CFG_HIGH_NICE, 16'(hi));
    cfg_valid_i = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_INSERT;
      else if (r < 65) op = OP_REMOVE;
      else if (r < 85) op = OP_REQUEUE;
      else             op = OP_PEEK;
      run_item(op, pick_id(), pick_nice(15), pick_now());
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    int lo;
    int hi;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_QUANTUM;
    cfg_data_i  = '0;
    push        = 1'b0;
    op_i        = OP_PEEK;
    task_id_i   = '0;
    nice_i      = '0;
    now_tick_i  = '0;
    error_count = 0;
    results_checked = 0;
    deepest     = 0;
    tick_base   = '0;
    send_calm_left = 0;
    // predictor starts from the reset state
    quantum   = QUANTUM_RST;
    low_nice  = LOW_NICE_RST;
    high_nice = HIGH_NICE_RST;
    rq_count  = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_fill_to_capacity();
    test_random_traffic(16'd6, -20, 19, 100);
    test_random_traffic(16'd0, -20, 19, 60);         // zero quantum, deadline is the tick
    test_random_traffic(16'hFFFF, -64, 63, 100);     // widest range, largest product
    test_random_traffic(16'd1, 63, -64, 30);         // empty range, every nice is bad
    test_random_traffic(16'd300, 0, 0, 40);          // a single allowed nice
    lo = int'($urandom_range(0, 127)) - 64;
    hi = lo + int'($urandom_range(0, 63 - lo));
    test_random_traffic(16'($urandom_range(1, 65535)), lo, hi, 100);

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d insert, %0d remove, %0d requeue, %0d peek; %0d results checked",
             op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_REQUEUE], op_seen[OP_PEEK],
             results_checked);
    $display("status ok %0d, full %0d, absent %0d, bad nice %0d; deepest queue %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_ABSENT],
             status_seen[ST_BAD_NICE], deepest);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/drq_pkg.sv
rtl/core/drq_front.sv
rtl/core/drq_cmd_queue.sv
rtl/core/drq_back.sv
rtl/core/deadline_ordered_run_queue_core.sv
sim/deadline_ordered_run_queue_core_tb.sv
